[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/cdu_pkg.sv]
package cdu_pkg;

	localparam int NUM_CH = 3;
	localparam int PIX_W = 8;
	localparam int MEAN_W = 16;
	localparam int A_W = 16;
	localparam int AXIS_W = NUM_CH * A_W;
	localparam int BAND_W = 18;
	localparam int RAD_W = 17;
	localparam int DIST_W = 8;

	localparam int D_W = 18;
	localparam int P_W = 34;
	localparam int T_W = 35;
	localparam int T_FRAC = 14;
	localparam int T8_W = 21;
	localparam int TA_W = 51;
	localparam int R_W = TA_W;
	localparam int R_FRAC = 28;
	localparam int DA_W = 24;
	localparam int M_W = 22;
	localparam int MM_W = 2 * M_W;
	localparam int SQ_W = 46;
	localparam int PERP_W = SQ_W / 2;
	localparam int SQRT_ITERS = PERP_W;
	localparam int DT_W = 23;

	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int CFG_ALIGN = 3;
	localparam int REG_IDX_W = ADDR_W - CFG_ALIGN;

	localparam logic [REG_IDX_W-1:0] REG_MEAN_BLUE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MEAN_GREEN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MEAN_RED = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_AXIS_VECTOR = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BAND_LOW = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BAND_HIGH = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd6;

	typedef struct packed {
		logic [NUM_CH-1:0][MEAN_W-1:0] mean;
		logic [AXIS_W-1:0] axis;
		logic [BAND_W-1:0] band_low;
		logic [BAND_W-1:0] band_high;
		logic [RAD_W-1:0] radius;
	} cdu_cfg_t;

	typedef struct packed {
		logic valid;
		logic [SQ_W-1:0] sq;
		logic [DT_W-1:0] dt;
	} cdu_sq_t;

	typedef struct packed {
		logic valid;
		logic [PERP_W-1:0] perp;
		logic [DT_W-1:0] dt;
	} cdu_perp_t;

endpackage

[rtl/color_cylinder_distance_unit.sv]
// Channel   Role     Beat contents
// s_axis    input    tdata: pixel_blue, pixel_green, pixel_red
// m_axis    output   tdata: distance
// apb       config   64-bit registers at byte address 8*index
//
// One beat is accepted per cycle while the skid entry is empty; a result passes through
// eight projection stages, twelve square-root stages of up to two root bits each,
// and the output register.
// Reset clears the configuration registers to zero and all valid bits.
// An output register and one skid entry follow the pipeline; the pipeline
// freezes only while the skid entry is full.
module color_cylinder_distance_unit import cdu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [7:0] pixel_blue, [15:8] pixel_green, [23:16] pixel_red
	input logic [NUM_CH*PIX_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [7:0] distance
	output logic [DIST_W-1:0] m_axis_tdata
);

	localparam int DP_W = PERP_W + 1;
	localparam int SUM_W = DP_W + 1;
	localparam int DIST_FRAC = 9;

	cdu_cfg_t cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic ce;
	logic [NUM_CH-1:0][PIX_W-1:0] pixel;
	cdu_sq_t sq_bus;
	cdu_perp_t perp_bus;
	logic [PERP_W-1:0] over;
	logic [DP_W-1:0] dp;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] rnd;
	logic [DIST_W-1:0] dist_c;
	logic arrival;
	logic o_vld_q, k_vld_q;
	logic [DIST_W-1:0] o_data_q, k_data_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:CFG_ALIGN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MEAN_BLUE: cfg_q.mean[0] <= pwdata[MEAN_W-1:0];
				REG_MEAN_GREEN: cfg_q.mean[1] <= pwdata[MEAN_W-1:0];
				REG_MEAN_RED: cfg_q.mean[2] <= pwdata[MEAN_W-1:0];
				REG_AXIS_VECTOR: cfg_q.axis <= pwdata[AXIS_W-1:0];
				REG_BAND_LOW: cfg_q.band_low <= pwdata[BAND_W-1:0];
				REG_BAND_HIGH: cfg_q.band_high <= pwdata[BAND_W-1:0];
				REG_RADIUS: cfg_q.radius <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MEAN_BLUE: prdata = DATA_W'(cfg_q.mean[0]);
			REG_MEAN_GREEN: prdata = DATA_W'(cfg_q.mean[1]);
			REG_MEAN_RED: prdata = DATA_W'(cfg_q.mean[2]);
			REG_AXIS_VECTOR: prdata = DATA_W'(cfg_q.axis);
			REG_BAND_LOW: prdata = DATA_W'(cfg_q.band_low);
			REG_BAND_HIGH: prdata = DATA_W'(cfg_q.band_high);
			REG_RADIUS: prdata = DATA_W'(cfg_q.radius);
			default: prdata = '0;
		endcase
	end

	assign ce = !k_vld_q;
	assign s_axis_tready = ce;
	assign pixel = s_axis_tdata;

	cdu_proj u_proj (
		.clk(clk),
		.arst_n(arst_n),
		.ce(ce),
		.in_valid(s_axis_tvalid),
		.pixel(pixel),
		.cfg(cfg_q),
		.sq_out(sq_bus)
	);

	cdu_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.ce(ce),
		.sq_in(sq_bus),
		.perp_out(perp_bus)
	);

	always_comb begin
		over = perp_bus.perp - PERP_W'(cfg_q.radius);
		dp = (perp_bus.perp > PERP_W'(cfg_q.radius)) ? {over, 1'b0} : '0;
		sum = SUM_W'(perp_bus.dt) + SUM_W'(dp);
		rnd = (sum + (SUM_W'(1) << (DIST_FRAC - 1))) >> DIST_FRAC;
		dist_c = (rnd > SUM_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : rnd[DIST_W-1:0];
	end

	assign arrival = ce && perp_bus.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
			k_vld_q <= 1'b0;
		end else if (k_vld_q) begin
			if (m_axis_tready) begin
				k_vld_q <= 1'b0;
			end
		end else if (arrival) begin
			if (!o_vld_q || m_axis_tready) begin
				o_vld_q <= 1'b1;
			end else begin
				k_vld_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (k_vld_q) begin
			if (m_axis_tready) begin
				o_data_q <= k_data_q;
			end
		end else if (arrival) begin
			if (!o_vld_q || m_axis_tready) begin
				o_data_q <= dist_c;
			end else begin
				k_data_q <= dist_c;
			end
		end
	end

	assign m_axis_tvalid = o_vld_q;
	assign m_axis_tdata = o_data_q;

endmodule

[rtl/cdu_proj.sv]
module cdu_proj import cdu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic ce,
	input logic in_valid,
	input logic [NUM_CH-1:0][PIX_W-1:0] pixel,
	input cdu_cfg_t cfg,
	output cdu_sq_t sq_out
);

	logic signed [A_W-1:0] a_c [NUM_CH];
	logic signed [D_W-1:0] d_c [NUM_CH];
	logic signed [P_W-1:0] p_c [NUM_CH];
	logic signed [T_W-1:0] t_c;
	logic signed [TA_W-1:0] ta_c [NUM_CH];
	logic [T_W-1:0] t_mag;
	logic [T_W-1:0] t_rnd;
	logic signed [T8_W-1:0] t8_c;
	logic signed [R_W-1:0] r_c [NUM_CH];
	logic signed [DA_W-1:0] dd_c;
	logic [DA_W-1:0] dabs_c;
	logic [R_W-1:0] r_mag [NUM_CH];
	logic [R_W-1:0] r_rnd [NUM_CH];
	logic [M_W-1:0] m_c [NUM_CH];
	logic signed [DA_W-1:0] wid_c;
	logic signed [DA_W-1:0] ex_c;
	logic [DT_W-1:0] dt_c;
	logic [MM_W-1:0] mm_c [NUM_CH];
	logic [SQ_W-1:0] sq_c;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [D_W-1:0] d_s1 [NUM_CH];
	logic signed [D_W-1:0] d_s2 [NUM_CH];
	logic signed [D_W-1:0] d_s3 [NUM_CH];
	logic signed [D_W-1:0] d_s4 [NUM_CH];
	logic signed [P_W-1:0] p_s2 [NUM_CH];
	logic signed [T_W-1:0] t_s3;
	logic signed [TA_W-1:0] ta_s4 [NUM_CH];
	logic signed [T8_W-1:0] t8_s4;
	logic signed [R_W-1:0] r_s5 [NUM_CH];
	logic [DA_W-1:0] dabs_s5;
	logic [M_W-1:0] m_s6 [NUM_CH];
	logic [DT_W-1:0] dt_s6;
	logic [MM_W-1:0] mm_s7 [NUM_CH];
	logic [DT_W-1:0] dt_s7;
	logic [SQ_W-1:0] sq_s8;
	logic [DT_W-1:0] dt_s8;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			a_c[c] = $signed(cfg.axis[c*A_W +: A_W]);
			d_c[c] = $signed({2'b00, pixel[c], 8'h00}) - $signed({2'b00, cfg.mean[c]});
			p_c[c] = P_W'(d_s1[c]) * P_W'(a_c[c]);
			ta_c[c] = TA_W'(t_s3) * TA_W'(a_c[c]);
			r_c[c] = (R_W'(d_s4[c]) <<< R_FRAC) - ta_s4[c];
			r_mag[c] = r_s5[c][R_W-1] ? R_W'(-r_s5[c]) : R_W'(r_s5[c]);
			r_rnd[c] = (r_mag[c] + (R_W'(1) << (R_FRAC - 1))) >> R_FRAC;
			m_c[c] = M_W'(r_rnd[c]);
			mm_c[c] = MM_W'(m_s6[c]) * MM_W'(m_s6[c]);
		end
	end

	always_comb begin
		t_c = '0;
		sq_c = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			t_c = t_c + T_W'(p_s2[c]);
			sq_c = sq_c + SQ_W'(mm_s7[c]);
		end
	end

	// Along-axis position rounded to Q.8, halves away from zero.
	always_comb begin
		t_mag = t_s3[T_W-1] ? T_W'(-t_s3) : T_W'(t_s3);
		t_rnd = (t_mag + (T_W'(1) << (T_FRAC - 1))) >> T_FRAC;
		t8_c = t_s3[T_W-1] ? -T8_W'(t_rnd) : T8_W'(t_rnd);
	end

	always_comb begin
		dd_c = (DA_W'(t8_s4) <<< 1)
			- (DA_W'($signed(cfg.band_low)) + DA_W'($signed(cfg.band_high)));
		dabs_c = dd_c[DA_W-1] ? DA_W'(-dd_c) : DA_W'(dd_c);
		wid_c = DA_W'($signed(cfg.band_high)) - DA_W'($signed(cfg.band_low));
		ex_c = $signed(dabs_s5) - wid_c;
		dt_c = ex_c[DA_W-1] ? '0 : DT_W'(ex_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int c = 0; c < NUM_CH; c++) begin
				d_s1[c] <= d_c[c];
				d_s2[c] <= d_s1[c];
				p_s2[c] <= p_c[c];
				d_s3[c] <= d_s2[c];
				d_s4[c] <= d_s3[c];
				ta_s4[c] <= ta_c[c];
				r_s5[c] <= r_c[c];
				m_s6[c] <= m_c[c];
				mm_s7[c] <= mm_c[c];
			end
			t_s3 <= t_c;
			t8_s4 <= t8_c;
			dabs_s5 <= dabs_c;
			dt_s6 <= dt_c;
			dt_s7 <= dt_s6;
			sq_s8 <= sq_c;
			dt_s8 <= dt_s7;
		end
	end

	assign sq_out.valid = vld_s8;
	assign sq_out.sq = sq_s8;
	assign sq_out.dt = dt_s8;

endmodule

[rtl/cdu_sqrt.sv]
module cdu_sqrt import cdu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic ce,
	input cdu_sq_t sq_in,
	output cdu_perp_t perp_out
);

	localparam int NSTG = (SQRT_ITERS + 1) / 2;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] res;
	} sqrt_acc_t;

	// One restoring step of the integer square root, trial bit 4^k.
	function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t cur, input int k);
		sqrt_acc_t nxt;
		logic [SQ_W-1:0] bit_v;
		logic [SQ_W-1:0] trial;
		bit_v = SQ_W'(1) << (2 * k);
		trial = cur.res + bit_v;
		if (cur.rem >= trial) begin
			nxt.rem = cur.rem - trial;
			nxt.res = (cur.res >> 1) + bit_v;
		end else begin
			nxt.rem = cur.rem;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

	sqrt_acc_t acc_s [NSTG];
	logic vld_s [NSTG];
	logic [DT_W-1:0] dt_s [NSTG];

	for (genvar j = 0; j < NSTG; j++) begin : g_stage
		sqrt_acc_t a_in;
		sqrt_acc_t a_mid;
		sqrt_acc_t a_out;
		logic v_in;
		logic [DT_W-1:0] dt_in;

		if (j == 0) begin : g_first
			assign a_in = '{rem: sq_in.sq, res: '0};
			assign v_in = sq_in.valid;
			assign dt_in = sq_in.dt;
		end else begin : g_next
			assign a_in = acc_s[j-1];
			assign v_in = vld_s[j-1];
			assign dt_in = dt_s[j-1];
		end

		assign a_mid = sqrt_step(a_in, SQRT_ITERS - 1 - 2 * j);

		if (2 * j + 1 < SQRT_ITERS) begin : g_two
			assign a_out = sqrt_step(a_mid, SQRT_ITERS - 2 - 2 * j);
		end else begin : g_one
			assign a_out = a_mid;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (ce) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				acc_s[j] <= a_out;
				dt_s[j] <= dt_in;
			end
		end
	end

	assign perp_out.valid = vld_s[NSTG-1];
	assign perp_out.perp = acc_s[NSTG-1].res[PERP_W-1:0];
	assign perp_out.dt = dt_s[NSTG-1];

endmodule

[rtl/cdu_checker.sv]
`include "assert_macros.svh"

module cdu_checker import cdu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic pready,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [DIST_W-1:0] m_axis_tdata
);

	logic out_stall;
	logic blue_wr;
	logic [MEAN_W-1:0] blue_rd;
	logic [MEAN_W-1:0] blue_wd;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign blue_wr = arst_n && psel && penable && pwrite && pready
		&& paddr[ADDR_W-1:CFG_ALIGN] == REG_MEAN_BLUE;
	assign blue_rd = prdata[MEAN_W-1:0];
	assign blue_wd = pwdata[MEAN_W-1:0];

	// The input side may only stall after the output side held a beat back.
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, !s_axis_tready, $past(out_stall))

	// With no result waiting, the skid entry is empty and input is taken.
	`ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// A write to the blue mean register reads back the written value.
	`ASSERT_IMPLY(a_cfg_readback, clk, arst_n, $past(blue_wr) && $stable(paddr), blue_rd == $past(blue_wd))

endmodule

bind color_cylinder_distance_unit cdu_checker u_checker (.*);

[bench/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdu_pkg::*;

	localparam int PIPE_LATENCY = 21;
	localparam int DRAIN_CYCLES = PIPE_LATENCY + 4;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASES_PER_MODE = 4;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int MAX_PRINTED = 200;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;
	typedef enum {STYLE_FIT, STYLE_RAW, STYLE_EDGE} setting_style_e;

	typedef struct {
		row_kind_e kind;
		logic [REG_IDX_W-1:0] idx;
		logic [DATA_W-1:0] value;
		logic [NUM_CH*PIX_W-1:0] px;
		bit known;
		logic [DIST_W-1:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// [7:0] pixel_blue, [15:8] pixel_green, [23:16] pixel_red
	logic [NUM_CH*PIX_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [7:0] distance
	logic [DIST_W-1:0] m_axis_tdata;

	logic [MEAN_W-1:0] cfg_mean [NUM_CH];
	logic [AXIS_W-1:0] cfg_axis;
	logic [BAND_W-1:0] cfg_band_low;
	logic [BAND_W-1:0] cfg_band_high;
	logic [RAD_W-1:0] cfg_radius;

	logic [DIST_W-1:0] expected_dist [$];
	stim_row_t directed_rows [$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int mismatches = 0;
	int results_checked = 0;
	int pixels_sent = 0;
	int settings_used = 0;

	color_cylinder_distance_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint round_half_away(longint x, int s);
		longint unsigned mag;
		mag = (x < 0) ? -x : x;
		mag = (mag + (64'd1 << (s - 1))) >> s;
		return (x < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	function automatic logic [DIST_W-1:0] cylinder_distance(logic [NUM_CH*PIX_W-1:0] px);
		longint diff [NUM_CH];
		longint comp [NUM_CH];
		longint along, along8, resid, lo, hi, along_excess, radial_excess, total;
		longint unsigned mag, sumsq, perp;
		along = 0;
		sumsq = 0;
		for (int c = 0; c < NUM_CH; c++) begin
			diff[c] = longint'(px[PIX_W*c +: PIX_W]) * 256 - longint'(cfg_mean[c]);
			comp[c] = longint'($signed(cfg_axis[A_W*c +: A_W]));
			along += diff[c] * comp[c];
		end
		along8 = round_half_away(along, T_FRAC);
		for (int c = 0; c < NUM_CH; c++) begin
			resid = diff[c] * (longint'(1) << R_FRAC) - along * comp[c];
			resid = round_half_away(resid, R_FRAC);
			mag = (resid < 0) ? -resid : resid;
			sumsq += mag * mag;
		end
		perp = int_sqrt(sumsq);
		lo = longint'($signed(cfg_band_low));
		hi = longint'($signed(cfg_band_high));
		along_excess = 2 * along8 - (lo + hi);
		if (along_excess < 0)
			along_excess = -along_excess;
		along_excess -= hi - lo;
		if (along_excess < 0)
			along_excess = 0;
		radial_excess = 2 * (longint'(perp) - longint'(cfg_radius));
		if (radial_excess < 0)
			radial_excess = 0;
		total = round_half_away(along_excess + radial_excess, 9);
		return (total > 255) ? 8'd255 : total[DIST_W-1:0];
	endfunction

	task automatic apply_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		case (idx)
			REG_MEAN_BLUE: cfg_mean[0] = value[MEAN_W-1:0];
			REG_MEAN_GREEN: cfg_mean[1] = value[MEAN_W-1:0];
			REG_MEAN_RED: cfg_mean[2] = value[MEAN_W-1:0];
			REG_AXIS_VECTOR: cfg_axis = value[AXIS_W-1:0];
			REG_BAND_LOW: cfg_band_low = value[BAND_W-1:0];
			REG_BAND_HIGH: cfg_band_high = value[BAND_W-1:0];
			REG_RADIUS: cfg_radius = value[RAD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_result(logic [DIST_W-1:0] got);
		logic [DIST_W-1:0] want;
		if (expected_dist.size() == 0) begin
			report_mismatch($sformatf("distance %0d arrived with no pixel pending", got));
			return;
		end
		want = expected_dist.pop_front();
		results_checked++;
		if (got !== want)
			report_mismatch($sformatf("distance got %0d, expected %0d", got, want));
	endtask

	// The pipeline drains completely here, so configuration changes never
	// overlap pixels in flight.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_dist.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, {CFG_ALIGN{1'b0}}};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drive_pixel(logic [NUM_CH*PIX_W-1:0] px, bit known, logic [DIST_W-1:0] want);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		expected_dist.insert(expected_dist.size(), known ? want : cylinder_distance(px));
		pixels_sent++;
	endtask

	function automatic void add_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		directed_rows.insert(directed_rows.size(),
			'{ROW_WRITE, idx, value, '0, 1'b0, '0});
	endfunction

	function automatic void add_pixel(int b, int g, int r, bit known, int want);
		directed_rows.insert(directed_rows.size(),
			'{ROW_PIXEL, '0, '0, {8'(r), 8'(g), 8'(b)}, known, 8'(want)});
	endfunction

	function automatic logic [NUM_CH*PIX_W-1:0] pick_pixel(bit near);
		logic [NUM_CH*PIX_W-1:0] px;
		int v;
		px = 24'($urandom);
		if (near) begin
			for (int c = 0; c < NUM_CH; c++) begin
				v = int'(cfg_mean[c][MEAN_W-1:8]) + int'($urandom_range(120)) - 60;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				px[PIX_W*c +: PIX_W] = 8'(v);
			end
		end
		return px;
	endfunction

	task automatic choose_setting(setting_style_e style);
		logic [DATA_W-1:0] mean_val [NUM_CH];
		logic [DATA_W-1:0] axis_val, low_val, high_val, radius_val;
		real vec [NUM_CH];
		real norm;
		int lo, hi, tmp;
		axis_val = '0;
		case (style)
			STYLE_FIT: begin
				for (int c = 0; c < NUM_CH; c++)
					mean_val[c] = 64'({8'($urandom_range(20, 235)), 8'($urandom)});
				do begin
					norm = 0.0;
					for (int c = 0; c < NUM_CH; c++) begin
						vec[c] = real'(int'($urandom_range(2000)) - 1000) / 1000.0;
						norm += vec[c] * vec[c];
					end
					norm = $sqrt(norm);
				end while (norm < 0.2);
				for (int c = 0; c < NUM_CH; c++)
					axis_val[A_W*c +: A_W] = 16'(int'(vec[c] / norm * 16384.0));
				lo = -int'($urandom_range(80 * 256));
				hi = $urandom_range(80 * 256);
				if ($urandom_range(9) == 0) begin
					tmp = lo;
					lo = hi;
					hi = tmp;
				end
				low_val = 64'(lo);
				high_val = 64'(hi);
				radius_val = 64'($urandom_range(30 * 256));
			end
			STYLE_RAW: begin
				for (int c = 0; c < NUM_CH; c++)
					mean_val[c] = {$urandom, $urandom};
				axis_val = {$urandom, $urandom};
				low_val = {$urandom, $urandom};
				high_val = {$urandom, $urandom};
				radius_val = {$urandom, $urandom};
			end
			default: begin
				for (int c = 0; c < NUM_CH; c++)
					mean_val[c] = $urandom_range(1) ? 64'hFFFF : 64'h0;
				for (int c = 0; c < NUM_CH; c++)
					axis_val[A_W*c +: A_W] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
				low_val = $urandom_range(1) ? 64'h2_0000 : 64'h1_FFFF;
				high_val = $urandom_range(1) ? 64'h2_0000 : 64'h1_FFFF;
				radius_val = $urandom_range(1) ? 64'h1_FFFF : 64'h0;
			end
		endcase
		write_register(REG_MEAN_BLUE, mean_val[0]);
		write_register(REG_MEAN_GREEN, mean_val[1]);
		write_register(REG_MEAN_RED, mean_val[2]);
		write_register(REG_AXIS_VECTOR, axis_val);
		write_register(REG_BAND_LOW, low_val);
		write_register(REG_BAND_HIGH, high_val);
		write_register(REG_RADIUS, radius_val);
		write_register(REG_UNUSED, {$urandom, $urandom});
		settings_used++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(m_axis_tdata);
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL color_cylinder_distance_unit");
		$finish;
	end

	initial begin : stimulus
		stim_row_t row;
		setting_style_e style;
		int directed_count;
		for (int c = 0; c < NUM_CH; c++)
			cfg_mean[c] = '0;
		cfg_axis = '0;
		cfg_band_low = '0;
		cfg_band_high = '0;
		cfg_radius = '0;

		// Cleared registers: the distance is the rounded length of the pixel.
		add_pixel(0, 0, 0, 1, 0);
		add_pixel(3, 4, 0, 1, 5);
		add_pixel(255, 255, 255, 1, 255);
		add_pixel(255, 0, 0, 1, 255);
		// Unit axis along channel 0, band covering the full pixel range.
		add_write(REG_AXIS_VECTOR, 64'h4000);
		add_write(REG_BAND_HIGH, 64'hFF00);
		add_pixel(100, 0, 0, 1, 0);
		add_pixel(255, 3, 4, 1, 5);
		add_pixel(0, 6, 8, 1, 10);
		add_write(REG_BAND_LOW, 64'h4000);
		add_write(REG_BAND_HIGH, 64'h8000);
		add_pixel(0, 0, 0, 1, 64);
		add_pixel(255, 0, 0, 1, 127);
		// Swapped limits add the width of the gap.
		add_write(REG_BAND_LOW, 64'h8000);
		add_write(REG_BAND_HIGH, 64'h4000);
		add_pixel(96, 0, 0, 1, 32);
		// An excess of exactly one half rounds up.
		add_write(REG_BAND_LOW, 64'h80);
		add_write(REG_BAND_HIGH, 64'h0);
		add_pixel(0, 0, 0, 1, 1);
		add_write(REG_BAND_LOW, 64'h0);
		add_write(REG_BAND_HIGH, 64'hFF00);
		add_write(REG_RADIUS, 64'h500);
		add_pixel(0, 6, 8, 1, 5);
		add_pixel(255, 3, 4, 1, 0);
		add_write(REG_BAND_LOW, 64'h2_0000);
		add_write(REG_BAND_HIGH, 64'h1_FFFF);
		add_write(REG_RADIUS, 64'h1_FFFF);
		add_pixel(255, 255, 255, 1, 0);
		add_pixel(0, 0, 0, 1, 0);
		// Upper bits beyond each register are dropped; the axis is far from unit length.
		add_write(REG_MEAN_BLUE, 64'hDEAD_BEEF_0000_FFFF);
		add_write(REG_MEAN_GREEN, 64'hFFFF);
		add_write(REG_MEAN_RED, 64'hFFFF_FFFF_FFFF_FFFF);
		add_write(REG_AXIS_VECTOR, 64'hFFFF_8000_8000_8000);
		add_write(REG_BAND_LOW, 64'h0);
		add_write(REG_BAND_HIGH, 64'h0);
		add_write(REG_RADIUS, 64'hFFFF_FFFF_FFFE_0000);
		add_pixel(0, 0, 0, 0, 0);
		add_pixel(255, 255, 255, 0, 0);
		add_pixel(0, 255, 0, 0, 0);
		add_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		add_pixel(128, 64, 200, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 20;
		sink_idle_pct = 20;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE)
				write_register(row.idx, row.value);
			else
				drive_pixel(row.px, row.known, row.want);
		end
		directed_count = pixels_sent;

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					src_idle_pct = 38;
					sink_idle_pct = 62;
				end
				1: begin
					src_idle_pct = 62;
					sink_idle_pct = 38;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
				style = (ph % 4 == 2) ? STYLE_RAW : (ph % 4 == 3) ? STYLE_EDGE : STYLE_FIT;
				choose_setting(style);
				for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
					if (mode == 0 && ph == 1 && n == 20)
						hold_asked <= hold_asked + 1;
					if (mode == 1 && ph == 0 && n == ITEMS_PER_PHASE / 2)
						settle();
					drive_pixel(pick_pixel(style == STYLE_FIT && $urandom_range(99) < 75),
						1'b0, '0);
				end
			end
		end
		settle();

		if (expected_dist.size() != 0)
			report_mismatch($sformatf("%0d pixels never produced a distance",
				expected_dist.size()));
		$display("Streamed %0d pixels (%0d directed) over %0d random register settings",
			pixels_sent, directed_count, settings_used);
		$display("Three idling mixes and a long output stall; %0d checked, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("PASS color_cylinder_distance_unit");
		else
			$display("FAIL color_cylinder_distance_unit");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/cdu_pkg.sv
rtl/cdu_proj.sv
rtl/cdu_sqrt.sv
rtl/color_cylinder_distance_unit.sv
rtl/cdu_checker.sv
bench/tb.sv
